>>> hw/rtl/pfk_pkg.sv
// ----------------------------------------------------------------------------
// pfk_pkg
// Shared types and constants of the potential-field kernel accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfk_pkg;

    localparam int PADDR_W = 4;

    typedef struct packed {
        logic signed [31:0] obs_x;
        logic signed [31:0] obs_y;
        logic signed [31:0] cell_x;
        logic signed [31:0] cell_y;
        logic        [30:0] cell_width;
        logic        [30:0] cell_thickness;
        logic signed [31:0] cell_value;
        logic signed [7:0]  pad_offset;
        logic               is_top_row;
        logic               last_cell;
    } t_pfk_in;

    typedef struct packed {
        logic signed [47:0] kernel_value;
        logic signed [63:0] anomaly_sum;
        logic               site_done;
    } t_pfk_out;

    localparam logic [46:0] KMAX       = '1;
    localparam logic [33:0] G2_Q40     = 34'd14671883161;
    localparam logic [7:0]  MAG_GAIN   = 8'd200;
    localparam logic [47:0] KERNEL_MIN = 48'h8000_0000_0000;

    localparam logic [1:0] REG_FIELD_MODE    = 2'd0;
    localparam logic [1:0] REG_SENSOR_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ZERO_TOP_ROW  = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/pfk_mul.sv
// ----------------------------------------------------------------------------
// pfk_mul
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfk_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_pv;
    logic [63:0]  r_p;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;

    logic [31:0] a_limb;
    logic [31:0] b_limb;
    logic [63:0] limb_prod;

    assign a_limb    = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_limb    = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign limb_prod = a_limb * b_limb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_p  <= limb_prod;
                    r_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                    r_pv <= 1'b1;
                end else begin
                    r_pv   <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                if (r_pv) begin
                    r_acc <= r_acc + ({64'd0, r_p} << {r_sh, 5'd0});
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

>>> hw/rtl/pfk_div.sv
// ----------------------------------------------------------------------------
// pfk_div
// Restoring radix-2 divider: 128-bit dividend, 81-bit divisor, 48-bit
// quotient with an overflow flag for quotients of 2^48 and more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfk_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [80:0]  i_den,
    output logic         o_done,
    output logic [47:0]  o_q,
    output logic         o_ovf
);

    localparam int QW = 48;

    logic [80:0]   r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;
    logic [80:0]   r_den;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_first;
    logic          r_done;
    logic          r_ovf;

    logic [81:0] shifted;
    logic [81:0] diff;
    logic        ge;

    assign shifted = {r_rem, r_low[QW-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem   <= {1'b0, i_num[127:QW]};
                r_low   <= i_num[QW-1:0];
                r_den   <= i_den;
                r_q     <= '0;
                r_cnt   <= 6'd0;
                r_busy  <= 1'b1;
                r_first <= 1'b1;
            end else if (r_busy) begin
                if (r_first) begin
                    r_first <= 1'b0;
                    if (r_rem >= r_den) begin
                        r_ovf  <= 1'b1;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ovf <= 1'b0;
                    end
                end else begin
                    r_rem <= ge ? diff[80:0] : shifted[80:0];
                    r_q   <= {r_q[QW-2:0], ge};
                    r_low <= {r_low[QW-2:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(QW - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

>>> hw/rtl/potential_field_kernel_accumulator_core.sv
// ----------------------------------------------------------------------------
// potential_field_kernel_accumulator_core
// Each transaction runs passes of the shared multiplier, plus one pass of the
// radix-2 divider for the gravity kernel and two for the magnetic kernel; a
// zeroed kernel skips the divider. One transaction at a time; the input
// stalls until the result is registered. Synchronous active-low reset clears
// the sequencer, the configuration registers and the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module potential_field_kernel_accumulator_core #(
    parameter int MAX_PAD = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pfk_pkg::t_pfk_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pfk_pkg::t_pfk_out                  o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pfk_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import pfk_pkg::*;

    localparam logic [7:0] PAD_LIM = (MAX_PAD > 128) ? 8'd128 : 8'(MAX_PAD);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WMUL  = 3'd2;
    localparam logic [2:0] S_WDIV  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [3:0] ST_PW    = 4'd0;
    localparam logic [3:0] ST_N     = 4'd1;
    localparam logic [3:0] ST_Z2    = 4'd2;
    localparam logic [3:0] ST_E2    = 4'd3;
    localparam logic [3:0] ST_CHK   = 4'd4;
    localparam logic [3:0] ST_GNZ   = 4'd5;
    localparam logic [3:0] ST_GDIV  = 4'd6;
    localparam logic [3:0] ST_GMUL  = 4'd7;
    localparam logic [3:0] ST_MDIV1 = 4'd8;
    localparam logic [3:0] ST_M200  = 4'd9;
    localparam logic [3:0] ST_MN    = 4'd10;
    localparam logic [3:0] ST_MDIV2 = 4'd11;
    localparam logic [3:0] ST_CON   = 4'd12;

    logic [2:0]         r_state;
    logic [3:0]         r_step;
    t_pfk_in            r_item;
    logic               r_mode;
    logic [30:0]        r_height;
    logic               r_ztop;
    logic [32:0]        r_zk;
    logic [39:0]        r_exm;
    logic [61:0]        r_n;
    logic [65:0]        r_z2;
    logic [79:0]        r_e2;
    logic [80:0]        r_r2;
    logic [127:0]       r_num;
    logic [47:0]        r_q;
    logic [46:0]        r_km;
    logic               r_kneg;
    logic signed [63:0] r_sum;
    logic               r_out_valid;
    t_pfk_out           r_out;

    logic         cfg_wr;
    logic         is_mul;
    logic         mul_start;
    logic         div_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_done;
    logic [47:0]  div_q;
    logic         div_ovf;

    logic [7:0]         padm_raw;
    logic [7:0]         padm;
    logic signed [40:0] dxo;
    logic signed [40:0] ex;
    logic [40:0]        ex_neg;
    logic [39:0]        exm;
    logic signed [32:0] gap;
    logic [32:0]        gapm;
    logic [32:0]        zk_calc;
    logic [80:0]        r2_sum;
    logic               z2_ge;
    logic [79:0]        dmag;
    logic [31:0]        vm;
    logic [54:0]        mag;
    logic               cneg;
    logic signed [64:0] contrib;
    logic signed [64:0] sum65;
    logic signed [63:0] sat_sum;
    logic [46:0]        km_m;
    logic [47:0]        kern;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_FIELD_MODE:    prdata = {31'd0, r_mode};
            REG_SENSOR_HEIGHT: prdata = {1'b0, r_height};
            REG_ZERO_TOP_ROW:  prdata = {31'd0, r_ztop};
            default:           prdata = '0;
        endcase
    end

    assign padm_raw = r_item.pad_offset[7] ? (~r_item.pad_offset + 8'd1) : r_item.pad_offset;
    assign padm     = (padm_raw > PAD_LIM) ? PAD_LIM : padm_raw;

    assign dxo    = {{9{r_item.obs_x[31]}}, r_item.obs_x} - {{9{r_item.cell_x[31]}}, r_item.cell_x};
    assign ex     = r_item.pad_offset[7] ? (dxo + {2'b0, mul_prod[38:0]})
                                         : (dxo - {2'b0, mul_prod[38:0]});
    assign ex_neg = 41'd0 - ex;
    assign exm    = ex[40] ? ex_neg[39:0] : ex[39:0];

    assign gap     = {r_item.obs_y[31], r_item.obs_y} - {r_item.cell_y[31], r_item.cell_y};
    assign gapm    = gap[32] ? (33'd0 - gap) : gap;
    assign zk_calc = gapm + {2'b0, r_height};

    assign r2_sum = {15'd0, r_z2} + {1'b0, mul_prod[79:0]};
    assign z2_ge  = {14'd0, r_z2} >= r_e2;
    assign dmag   = z2_ge ? ({14'd0, r_z2} - r_e2) : (r_e2 - {14'd0, r_z2});

    assign vm      = r_item.cell_value[31] ? (32'd0 - r_item.cell_value) : r_item.cell_value;
    assign mag     = mul_prod[78:24];
    assign cneg    = r_item.cell_value[31] ^ r_kneg;
    assign contrib = cneg ? (65'sd0 - $signed({10'd0, mag})) : $signed({10'd0, mag});
    assign sum65   = {r_sum[63], r_sum} + contrib;
    assign sat_sum = (sum65[64] != sum65[63]) ? (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                                              : sum65[63:0];

    assign km_m = (div_ovf || div_q[47]) ? KMAX : div_q[46:0];
    assign kern = r_kneg ? (48'd0 - {1'b0, r_km}) : {1'b0, r_km};

    always_comb begin
        unique case (r_step)
            ST_PW:   begin mul_a = {56'd0, padm};               mul_b = {33'd0, r_item.cell_width}; end
            ST_N:    begin mul_a = {33'd0, r_item.cell_width};  mul_b = {33'd0, r_item.cell_thickness}; end
            ST_Z2:   begin mul_a = {31'd0, r_zk};               mul_b = {31'd0, r_zk}; end
            ST_E2:   begin mul_a = {24'd0, r_exm};              mul_b = {24'd0, r_exm}; end
            ST_GNZ:  begin mul_a = {2'd0, r_n};                 mul_b = {31'd0, r_zk}; end
            ST_GMUL: begin mul_a = {30'd0, G2_Q40};             mul_b = {16'd0, r_q}; end
            ST_M200: begin mul_a = {56'd0, MAG_GAIN};           mul_b = {16'd0, r_q}; end
            ST_MN:   begin mul_a = {16'd0, r_q};                mul_b = {2'd0, r_n}; end
            ST_CON:  begin mul_a = {17'd0, r_km};               mul_b = {32'd0, vm}; end
            default: begin mul_a = '0;                          mul_b = '0; end
        endcase
    end

    assign is_mul = (r_step != ST_CHK) && (r_step != ST_GDIV) &&
                    (r_step != ST_MDIV1) && (r_step != ST_MDIV2);
    assign mul_start = (r_state == S_ISSUE) && is_mul;
    assign div_start = (r_state == S_ISSUE) && !is_mul && (r_step != ST_CHK);

    pfk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pfk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_r2),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_ovf   (div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_PW;
            r_mode      <= 1'b0;
            r_height    <= '0;
            r_ztop      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_FIELD_MODE:    r_mode   <= pwdata[0];
                    REG_SENSOR_HEIGHT: r_height <= pwdata[30:0];
                    REG_ZERO_TOP_ROW:  r_ztop   <= pwdata[0];
                    default:           ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_step  <= ST_PW;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_step == ST_PW) begin
                        r_zk <= zk_calc;
                    end
                    if (r_step == ST_CHK) begin
                        if ((r_ztop && r_item.is_top_row) || (r_r2 == '0)) begin
                            r_km   <= '0;
                            r_kneg <= 1'b0;
                            r_step <= ST_CON;
                        end else if (!r_mode) begin
                            r_kneg <= 1'b0;
                            r_step <= ST_GNZ;
                        end else begin
                            r_num  <= {16'd0, dmag, 32'd0};
                            r_kneg <= !z2_ge;
                            r_step <= ST_MDIV1;
                        end
                    end else if (is_mul) begin
                        r_state <= S_WMUL;
                    end else begin
                        r_state <= S_WDIV;
                    end
                end
                S_WMUL: begin
                    if (mul_done) begin
                        r_state <= S_ISSUE;
                        unique case (r_step)
                            ST_PW: begin
                                r_exm  <= exm;
                                r_step <= ST_N;
                            end
                            ST_N: begin
                                r_n    <= mul_prod[61:0];
                                r_step <= ST_Z2;
                            end
                            ST_Z2: begin
                                r_z2   <= mul_prod[65:0];
                                r_step <= ST_E2;
                            end
                            ST_E2: begin
                                r_e2   <= mul_prod[79:0];
                                r_r2   <= r2_sum;
                                r_step <= ST_CHK;
                            end
                            ST_GNZ: begin
                                r_num  <= {mul_prod[111:0], 16'd0};
                                r_step <= ST_GDIV;
                            end
                            ST_GMUL: begin
                                r_km   <= (mul_prod[127:79] != '0) ? KMAX : mul_prod[78:32];
                                r_step <= ST_CON;
                            end
                            ST_M200: begin
                                r_q    <= mul_prod[47:0];
                                r_step <= ST_MN;
                            end
                            ST_MN: begin
                                r_num  <= mul_prod;
                                r_step <= ST_MDIV2;
                            end
                            default: begin
                                r_sum   <= sat_sum;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_state <= S_ISSUE;
                        unique case (r_step)
                            ST_GDIV: begin
                                if (div_ovf) begin
                                    r_km   <= KMAX;
                                    r_step <= ST_CON;
                                end else begin
                                    r_q    <= div_q;
                                    r_step <= ST_GMUL;
                                end
                            end
                            ST_MDIV1: begin
                                r_q    <= div_q;
                                r_step <= ST_M200;
                            end
                            default: begin
                                r_km   <= km_m;
                                r_kneg <= r_kneg && (km_m != '0);
                                r_step <= ST_CON;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.kernel_value <= kern;
                        r_out.anomaly_sum  <= r_sum;
                        r_out.site_done    <= r_item.last_cell;
                        r_out_valid        <= 1'b1;
                        if (r_item.last_cell) begin
                            r_sum <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/pfk_checker.sv
// ----------------------------------------------------------------------------
// pfk_checker
// Port-level checks of the kernel accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfk_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pfk_pkg::t_pfk_out o_out_data
);

    import pfk_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transaction");

    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without a transaction in work");

    a_kernel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.kernel_value != KERNEL_MIN)
        else $error("kernel magnitude beyond saturation limit");

endmodule

bind potential_field_kernel_accumulator_core pfk_checker u_pfk_checker (.*);

`default_nettype wire
